### rtl/ipc_pkg.sv
// Shared types and constants of the interactivity priority calculator.
// No dependencies; used by ipc_cfg and the top level.
package ipc_pkg;

	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned SCORE_W = 8;
	localparam int unsigned PROD_W = 16;

	typedef enum logic [ADDR_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_PRI_MIN   = 3'd1,
		REG_PRI_MAX   = 3'd2,
		REG_BATCH_BASE = 3'd3,
		REG_BATCH_RANGE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [6:0] threshold;
		logic [7:0] pri_min;
		logic [7:0] pri_max;
		logic [7:0] batch_base;
		logic [7:0] batch_range;
	} cfg_t;

	// Task fields carried alongside the ratio divider pipeline.
	typedef struct packed {
		logic        tshare;
		logic        ticks;
		logic [5:0]  nice;
		logic [7:0]  tickp;
		logic [7:0]  lent;
		logic        early;
		logic        run_gt;
		logic        run_eq;
		logic        run_nz;
	} side_t;

	typedef struct packed {
		logic [TIME_W-1:0] lesser;
		side_t             side;
	} side1_t;

	typedef struct packed {
		logic               tshare;
		logic [SCORE_W-1:0] score;
		logic               inter;
		logic               neg;
		logic [7:0]         bpri;
		logic [7:0]         lent;
	} side3_t;

endpackage

### rtl/ipc_cfg.sv
// Configuration register file of the interactivity priority calculator.
// Depends on ipc_pkg.
module ipc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [ipc_pkg::ADDR_W-1:0]   wr_idx,
	input  logic [ipc_pkg::DATA_W-1:0]   wr_data,
	output ipc_pkg::cfg_t                cfg
);
	import ipc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= 7'd30;
			cfg_q.pri_min     <= 8'd120;
			cfg_q.pri_max     <= 8'd135;
			cfg_q.batch_base  <= 8'd156;
			cfg_q.batch_range <= 8'd48;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_idx))
				REG_THRESHOLD:   cfg_q.threshold   <= wr_data[6:0];
				REG_PRI_MIN:     cfg_q.pri_min     <= wr_data;
				REG_PRI_MAX:     cfg_q.pri_max     <= wr_data;
				REG_BATCH_BASE:  cfg_q.batch_base  <= wr_data;
				REG_BATCH_RANGE: cfg_q.batch_range <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/ipc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No dependencies.
module ipc_div #(
	parameter int unsigned W  = 32,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [W-1:0]  quo,
	output logic [SW-1:0] side_out
);
	logic          vld_s  [W+1];
	logic [W-1:0]  rem_s  [W+1];
	logic [W-1:0]  nq_s   [W+1];
	logic [W-1:0]  den_s  [W+1];
	logic [SW-1:0] side_s [W+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign nq_s[0]   = num;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W:0]   shl;
		logic         ge;
		logic [W:0]   diff;

		assign shl  = {rem_s[i], nq_s[i][W-1]};
		assign ge   = shl >= {1'b0, den_s[i]};
		assign diff = shl - {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge ? diff[W-1:0] : shl[W-1:0];
			nq_s[i+1]   <= {nq_s[i][W-2:0], ge};
			den_s[i+1]  <= den_s[i];
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_vld  = vld_s[W];
	assign quo      = nq_s[W];
	assign side_out = side_s[W];

endmodule

### rtl/interactivity_priority_calc_unit.sv
// Top level of the interactivity priority calculator.
// Depends on ipc_pkg, ipc_cfg and ipc_div.
//
// The unit takes one task item per clock (busy is always low) and returns one
// result per item, strobed by done for a single cycle. Three register stages
// take the item and divide the larger time by the half score through a
// two-stage reciprocal multiply; two bit-serial divider pipelines then divide
// the smaller time by that quotient (32 stages) and the band product by the
// threshold (16 stages), with one register stage between them and one at the
// output. Results cannot be held off. The user must write the registers
// through wr_en/wr_idx/wr_data only while no item is in flight; the block
// itself does not enforce this.
module interactivity_priority_calc_unit #(
	parameter int unsigned INTERACT_HALF = 50
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [ipc_pkg::ADDR_W-1:0]  wr_idx,
	input  logic [ipc_pkg::DATA_W-1:0]  wr_data,
	input  logic                        start,
	output logic                        busy,
	input  logic [31:0]                 run_time,
	input  logic [31:0]                 sleep_time,
	input  logic signed [5:0]           nice_value,
	input  logic                        is_timeshare,
	input  logic                        has_ticks,
	input  logic [7:0]                  tick_priority,
	input  logic [7:0]                  lent_priority,
	output logic                        done,
	output logic                        valid_res,
	output logic [6:0]                  score,
	output logic                        is_interactive,
	output logic [7:0]                  base_priority,
	output logic                        user_pri_update
);
	import ipc_pkg::*;

	localparam logic [SCORE_W-1:0] HALF_S  = SCORE_W'(INTERACT_HALF);
	localparam logic [SCORE_W-1:0] TWO_H_S = SCORE_W'(2 * INTERACT_HALF);

	// Reciprocal of the half score: floor(x / HALF) = (x * RECIP_M) >> RECIP_S
	// for every 32-bit x.
	localparam int unsigned MUL_W   = TIME_W + 1;
	localparam int unsigned LO_W    = TIME_W / 2;
	localparam int unsigned PP_W    = MUL_W + LO_W;
	localparam int unsigned SUM_W   = PP_W + LO_W;
	localparam int unsigned RECIP_S = TIME_W + $clog2(INTERACT_HALF);
	localparam logic [MUL_W-1:0] RECIP_M = MUL_W'(((64'd1 << RECIP_S) +
		64'(INTERACT_HALF) - 64'd1) / 64'(INTERACT_HALF));

	cfg_t cfg;

	ipc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.cfg     (cfg)
	);

	// Never stall the producer: every stage advances each cycle.
	assign busy = 1'b0;

	// Stage 1: register the item, order the two times, flag special cases.
	logic              vld_s1;
	logic [TIME_W-1:0] big_s1;
	side1_t            sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		big_s1            <= (run_time > sleep_time) ? run_time : sleep_time;
		sd_s1.lesser      <= (run_time > sleep_time) ? sleep_time : run_time;
		sd_s1.side.tshare <= is_timeshare;
		sd_s1.side.ticks  <= has_ticks;
		sd_s1.side.nice   <= nice_value;
		sd_s1.side.tickp  <= tick_priority;
		sd_s1.side.lent   <= lent_priority;
		// Early exit for likely batch tasks when the threshold allows it.
		sd_s1.side.early  <= ({1'b0, cfg.threshold} <= HALF_S) &&
			(run_time >= sleep_time);
		sd_s1.side.run_gt <= run_time > sleep_time;
		sd_s1.side.run_eq <= run_time == sleep_time;
		sd_s1.side.run_nz <= run_time != '0;
	end

	// Stage 2: multiply each half of the larger time by the reciprocal.
	logic            vld_s2;
	logic [PP_W-1:0] pph_s2;
	logic [PP_W-1:0] ppl_s2;
	side1_t          sd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pph_s2 <= PP_W'(big_s1[TIME_W-1:LO_W]) * PP_W'(RECIP_M);
		ppl_s2 <= PP_W'(big_s1[LO_W-1:0]) * PP_W'(RECIP_M);
		sd_s2  <= sd_s1;
	end

	// Stage 3: recombine the partial products, shift the quotient down and
	// clamp the divisor to at least one.
	logic [SUM_W-1:0]  recip_prod;
	logic [TIME_W-1:0] q_half;

	assign recip_prod = {pph_s2, LO_W'(0)} + SUM_W'(ppl_s2);
	assign q_half     = TIME_W'(recip_prod >> RECIP_S);

	logic              vld_s3;
	logic [TIME_W-1:0] div_s3;
	side1_t            sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		div_s3 <= (q_half == '0) ? TIME_W'(1) : q_half;
		sd_s3  <= sd_s2;
	end

	// Divide the smaller time by the clamped quotient.
	logic              vld_d1;
	logic [TIME_W-1:0] q_d1;
	side_t             sd_d1;

	ipc_div #(.W(TIME_W), .SW($bits(side_t))) u_div_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.num      (sd_s3.lesser),
		.den      (div_s3),
		.side_in  (sd_s3.side),
		.out_vld  (vld_d1),
		.quo      (q_d1),
		.side_out (sd_d1)
	);

	// Stage 4: form the score, add nice, decide interactive, build the band
	// product and the batch priority.
	logic [SCORE_W-1:0] raw_sc;
	logic signed [9:0]  adj;
	logic [8:0]         adj_c;
	logic               inter;
	logic signed [9:0]  span;
	logic [8:0]         span_mag;
	logic [7:0]         cap;
	logic [7:0]         tick_term;
	logic [7:0]         bpri;

	always_comb begin
		if (sd_d1.early) begin
			raw_sc = HALF_S;
		end else if (sd_d1.run_eq) begin
			raw_sc = sd_d1.run_nz ? HALF_S : '0;
		end else if (sd_d1.run_gt) begin
			raw_sc = (q_d1 >= TIME_W'(TWO_H_S)) ? '0 : (TWO_H_S - q_d1[SCORE_W-1:0]);
		end else begin
			raw_sc = q_d1[SCORE_W-1:0];
		end
		adj   = $signed({2'b00, raw_sc}) + 10'(signed'(sd_d1.nice));
		adj_c = adj[9] ? 9'd0 : adj[8:0];
		inter = adj_c < {2'b00, cfg.threshold};

		span     = $signed({2'b00, cfg.pri_max}) - $signed({2'b00, cfg.pri_min}) + 10'sd1;
		span_mag = span[9] ? 9'(-span) : span[8:0];

		cap       = (cfg.batch_range == '0) ? '0 : cfg.batch_range - 8'd1;
		tick_term = sd_d1.ticks ? ((sd_d1.tickp < cap) ? sd_d1.tickp : cap) : '0;
		bpri      = cfg.batch_base + tick_term + 8'(signed'(sd_d1.nice));
	end

	logic              vld_s4;
	logic [PROD_W-1:0] prod_s4;
	side3_t            sd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_d1;
		end
	end

	always_ff @(posedge clk) begin
		// Only the interactive case uses the product, where adj < 128.
		prod_s4       <= {7'd0, span_mag} * {9'd0, adj_c[6:0]};
		sd_s4.tshare  <= sd_d1.tshare;
		sd_s4.score   <= raw_sc;
		sd_s4.inter   <= inter;
		sd_s4.neg     <= span[9];
		sd_s4.bpri    <= bpri;
		sd_s4.lent    <= sd_d1.lent;
	end

	// Divide the band product by the threshold.
	logic              vld_d2;
	logic [PROD_W-1:0] q_d2;
	side3_t            sd_d2;

	ipc_div #(.W(PROD_W), .SW($bits(side3_t))) u_div_band (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.num      (prod_s4),
		.den      ({9'd0, cfg.threshold}),
		.side_in  (sd_s4),
		.out_vld  (vld_d2),
		.quo      (q_d2),
		.side_out (sd_d2)
	);

	// Stage 5: pick the priority, zero everything for non-timeshare tasks.
	logic [7:0] p8;

	always_comb begin
		if (sd_d2.inter) begin
			p8 = cfg.pri_min + (sd_d2.neg ? 8'(-q_d2[7:0]) : q_d2[7:0]);
		end else begin
			p8 = sd_d2.bpri;
		end
	end

	logic       done_q;
	logic       valid_q;
	logic [6:0] score_q;
	logic       inter_q;
	logic [7:0] pri_q;
	logic       upd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_d2;
		end
	end

	always_ff @(posedge clk) begin
		valid_q <= sd_d2.tshare;
		score_q <= sd_d2.tshare ? sd_d2.score[6:0] : '0;
		inter_q <= sd_d2.tshare & sd_d2.inter;
		pri_q   <= sd_d2.tshare ? p8 : '0;
		upd_q   <= sd_d2.tshare & (sd_d2.lent > p8);
	end

	assign done            = done_q;
	assign valid_res       = valid_q;
	assign score           = score_q;
	assign is_interactive  = inter_q;
	assign base_priority   = pri_q;
	assign user_pri_update = upd_q;

endmodule

### test/tb_interactivity_priority_calc_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the interactivity priority calculator.
// Depends on ipc_pkg and interactivity_priority_calc_unit; predicts each result in SV.
module tb_interactivity_priority_calc_unit;
	import ipc_pkg::*;

	localparam int HALF = 50;
	localparam int LATENCY = 53;
	localparam longint CYCLE_LIMIT = 1_500_000;

	typedef struct packed {
		logic [31:0] run_t;
		logic [31:0] sleep_t;
		logic [5:0]  nice;
		logic        tshare;
		logic        ticks;
		logic [7:0]  tickp;
		logic [7:0]  lent;
	} task_item_t;

	typedef struct packed {
		logic       vld;
		logic [6:0] scr;
		logic       inter;
		logic [7:0] bpri;
		logic       upd;
	} prio_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [ADDR_W-1:0] wr_idx = '0;
	logic [DATA_W-1:0] wr_data = '0;
	logic start = 1'b0;
	logic busy;
	logic [31:0] run_time = '0;
	logic [31:0] sleep_time = '0;
	logic signed [5:0] nice_value = '0;
	logic is_timeshare = 1'b0;
	logic has_ticks = 1'b0;
	logic [7:0] tick_priority = '0;
	logic [7:0] lent_priority = '0;
	logic done;
	logic valid_res;
	logic [6:0] score;
	logic is_interactive;
	logic [7:0] base_priority;
	logic user_pri_update;

	// Shadow copy of the block's registers.
	longint thr_q = 30, pmin_q = 120, pmax_q = 135, bbase_q = 156, brange_q = 48;

	prio_t expected_prio_q[$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int sender_idle_pct = 0;
	longint cycles = 0;

	always #6 clk = ~clk;

	interactivity_priority_calc_unit #(.INTERACT_HALF(HALF)) u_top (.*);

	// Raw sleep/run score; the early exit only applies with a low threshold.
	function automatic longint sleep_run_score(longint r, longint s);
		longint d, v;
		if (thr_q <= HALF && r >= s) return HALF;
		if (r > s) begin
			d = r / HALF;
			if (d < 1) d = 1;
			v = 2 * HALF - s / d;
			return (v < 0) ? 0 : v;
		end
		if (s > r) begin
			d = s / HALF;
			if (d < 1) d = 1;
			return r / d;
		end
		return (r != 0) ? HALF : 0;
	endfunction

	function automatic prio_t calc_priority(task_item_t t);
		prio_t p;
		longint sc, adj, pri, cap, nc;
		logic [7:0] p8;
		p = '0;
		if (!t.tshare) return p;
		nc = longint'($signed(t.nice));
		sc = sleep_run_score(longint'(t.run_t), longint'(t.sleep_t));
		adj = sc + nc;
		if (adj < 0) adj = 0;
		p.inter = adj < thr_q;
		if (p.inter) begin
			pri = pmin_q + (pmax_q - pmin_q + 1) * adj / thr_q;
		end else begin
			pri = bbase_q;
			if (t.ticks) begin
				cap = (brange_q == 0) ? 0 : brange_q - 1;
				pri += (t.tickp < cap) ? t.tickp : cap;
			end
			pri += nc;
		end
		p8 = pri[7:0];
		p.vld = 1'b1;
		p.scr = sc[6:0];
		p.bpri = p8;
		p.upd = t.lent > p8;
		return p;
	endfunction

	// Compare every strobed result against the oldest prediction.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) begin
			prio_t got, exp_p;
			got = '{valid_res, score, is_interactive, base_priority, user_pri_update};
			results_seen <= results_seen + 1;
			if (expected_prio_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors <= errors + 1;
			end else begin
				exp_p = expected_prio_q.pop_front();
				if (got !== exp_p) begin
					$display("%0t: mismatch expected vld=%b score=%0d inter=%b pri=%0d upd=%b",
						$time, exp_p.vld, exp_p.scr, exp_p.inter, exp_p.bpri, exp_p.upd);
					$display("%0t:          actual   vld=%b score=%0d inter=%b pri=%0d upd=%b",
						$time, got.vld, got.scr, got.inter, got.bpri, got.upd);
					errors <= errors + 1;
				end
			end
		end
	end

	// Abort a hung run.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("tb: failure");
			$finish;
		end
	end

	// Drive one item at the falling edge and hold it until accepted; start
	// stays high on return so items can follow back to back.
	task automatic send_item(task_item_t t);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		{run_time, sleep_time, nice_value, is_timeshare, has_ticks,
			tick_priority, lent_priority} <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_prio_q = {expected_prio_q, calc_priority(t)};
		items_sent++;
		@(negedge clk);
	endtask

	// Drop start and hold off until every expected result has arrived.
	task automatic pause_until_empty();
		start <= 1'b0;
		@(negedge clk);
		while (expected_prio_q.size() != 0) @(negedge clk);
	endtask

	// Wait for the pipeline to drain before touching registers.
	task automatic drain();
		pause_until_empty();
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [7:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_THRESHOLD:   thr_q = val[6:0];
			REG_PRI_MIN:     pmin_q = val;
			REG_PRI_MAX:     pmax_q = val;
			REG_BATCH_BASE:  bbase_q = val;
			REG_BATCH_RANGE: brange_q = val;
			default: ;
		endcase
	endtask

	task automatic set_config(int thr, int pmin, int pmax, int bb, int br);
		drain();
		write_reg(REG_THRESHOLD, thr[7:0]);
		write_reg(REG_PRI_MIN, pmin[7:0]);
		write_reg(REG_PRI_MAX, pmax[7:0]);
		write_reg(REG_BATCH_BASE, bb[7:0]);
		write_reg(REG_BATCH_RANGE, br[7:0]);
	endtask

	function automatic task_item_t mk(longint r, longint s, int n, bit ts, bit tk,
			int tp, int ln);
		task_item_t t;
		t.run_t = r[31:0];
		t.sleep_t = s[31:0];
		t.nice = n[5:0];
		t.tshare = ts;
		t.ticks = tk;
		t.tickp = tp[7:0];
		t.lent = ln[7:0];
		return t;
	endfunction

	// Random task; mostly sensible times, sometimes the full 32-bit range.
	function automatic task_item_t rand_item();
		task_item_t t;
		t.run_t = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(5000);
		t.sleep_t = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(5000);
		if ($urandom_range(9) == 0) t.sleep_t = t.run_t;
		t.nice = ($urandom_range(9) == 0) ? 6'($urandom()) : 6'($urandom_range(40) - 20);
		t.tshare = $urandom_range(7) != 0;
		t.ticks = 1'($urandom_range(1));
		t.tickp = 8'($urandom());
		t.lent = 8'($urandom());
		return t;
	endfunction

	// Extremes of every field and each named corner.
	task automatic test_directed();
		send_item(mk(10, 20, 0, 0, 1, 5, 255));              // not timeshare
		send_item(mk(0, 0, 0, 1, 0, 0, 0));                  // both times zero
		send_item(mk(500, 100, 0, 1, 1, 10, 200));           // early exit
		send_item(mk(100, 100, 0, 1, 0, 0, 200));            // equal times
		send_item(mk(0, 32'hFFFF_FFFF, -20, 1, 0, 0, 255));  // fully sleeping, low nice
		send_item(mk(32'hFFFF_FFFF, 0, 19, 1, 1, 255, 0));
		send_item(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, -32, 1, 1, 255, 255));
		send_item(mk(3, 7, 31, 1, 1, 0, 128));
		send_item(mk(40, 10000, 20, 1, 1, 47, 160));
		set_config(100, 200, 100, 250, 0);                   // inverted band, zero range
		send_item(mk(500, 100, 0, 1, 1, 200, 0));            // no early exit now
		send_item(mk(100, 100, 0, 1, 1, 200, 255));
		send_item(mk(0, 0, -20, 1, 1, 255, 255));
		send_item(mk(32'hFFFF_FFFF, 1, 20, 1, 1, 255, 1));
		send_item(mk(1, 32'hFFFF_FFFF, 0, 1, 0, 0, 3));
		set_config(0, 255, 255, 255, 255);                   // never interactive, wrap
		send_item(mk(1000, 2000, 20, 1, 1, 255, 3));
		send_item(mk(2000, 1000, -20, 1, 0, 9, 255));
		send_item(mk(0, 0, 0, 1, 1, 254, 0));
		set_config(127, 0, 0, 0, 1);
		send_item(mk(10, 5000, 0, 1, 1, 100, 1));
		send_item(mk(5000, 10, -1, 1, 1, 100, 255));
	endtask

	task automatic run_random(int n, int idle_pct);
		sender_idle_pct = idle_pct;
		repeat (n) begin
			// Occasionally stop and let the pipeline empty.
			if ($urandom_range(199) == 0)
				pause_until_empty();
			send_item(rand_item());
		end
		sender_idle_pct = 0;
	endtask

	task automatic test_random();
		set_config(30, 120, 135, 156, 48);
		run_random(300, 0);
		set_config($urandom_range(127), $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255));
		run_random(300, 74);
		set_config(60, 140, 100, 200, 0);
		run_random(300, 0);
		set_config($urandom_range(100), $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(1, 255));
		run_random(300, 17);
		// Hold off until every result has arrived once.
		pause_until_empty();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		drain();
		$display("tb: %0d items sent, %0d results checked over several register settings",
			items_sent, results_seen);
		if (errors == 0 && expected_prio_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
